// File: src/frkd_pkg.sv
// Package for the framed repeating-key decryptor.
// Holds the item payload types and the frame phase codes; no dependencies.
package frkd_pkg;

	typedef enum logic [1:0] {
		PH_DELIM = 2'd0,
		PH_KEY   = 2'd1,
		PH_MSG   = 2'd2,
		PH_ERR   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       status;
		logic       end_of_frame;
	} out_item_t;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_KEY_LONG = 1'b1;

endpackage

// File: src/framed_repeating_key_decrypt.sv
// Framed repeating-key decryptor: delimiter, key bytes, ciphertext bytes.
// Each result item passes stage 1 (with its key RAM read), then the output register.
// Throughput: one item per cycle unless the output stalls; one key RAM read per item.
// A stalled output holds one result and one more in flight before ready drops.
// Reset (arst_n low) returns the block to expecting a delimiter; key RAM is not cleared.
// Depends on frkd_pkg and frkd_ram.
module framed_repeating_key_decrypt #(
	parameter int KEY_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  frkd_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output frkd_pkg::out_item_t result
);

	import frkd_pkg::*;

	localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int CW = $clog2(KEY_DEPTH + 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(KEY_DEPTH);

	phase_t          phase_q, phase_d;
	logic [7:0]      delim_q, delim_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]   pos_q, pos_d;

	logic            item_fire;
	logic            produce, is_err, use_key, wr_en;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   p_cur;
	logic [CW-1:0]   p_inc;
	logic [7:0]      key_byte;

	logic            valid_s1, err_s1, use_key_s1, last_s1;
	logic [7:0]      data_s1;
	logic            s1_adv;

	logic            result_valid_q;
	out_item_t       result_q;

	assign s1_adv     = !result_valid_q || result_ready;
	assign item_ready = !valid_s1 || s1_adv;
	assign item_fire  = item_valid && item_ready;

	always_comb begin
		phase_d = phase_q;
		delim_d = delim_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		produce = 1'b0;
		is_err  = 1'b0;
		use_key = 1'b0;
		wr_en   = 1'b0;
		p_cur   = (CW'(pos_q) >= cnt_q) ? '0 : pos_q;
		p_inc   = CW'(p_cur) + CW'(1);
		rd_addr = p_cur;
		case (phase_q)
			PH_DELIM: begin
				delim_d = item.data_byte;
				cnt_d   = '0;
				pos_d   = '0;
				phase_d = PH_KEY;
			end
			PH_KEY: begin
				if (item.data_byte == delim_q) begin
					pos_d   = '0;
					phase_d = PH_MSG;
				end else if (cnt_q == COUNT_FULL) begin
					produce = 1'b1;
					is_err  = 1'b1;
					phase_d = PH_ERR;
				end else begin
					wr_en = 1'b1;
					cnt_d = cnt_q + CW'(1);
				end
			end
			PH_MSG: begin
				produce = 1'b1;
				if (cnt_q != '0) begin
					use_key = 1'b1;
					pos_d   = (p_inc >= cnt_q) ? '0 : p_inc[AW-1:0];
				end
			end
			PH_ERR: begin
				// rest of the frame is dropped
			end
			default: begin
				phase_d = PH_DELIM;
			end
		endcase
		if (item.frame_last) begin
			phase_d = PH_DELIM;
			pos_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELIM;
			delim_q <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else if (item_fire) begin
			phase_q <= phase_d;
			delim_q <= delim_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
		end
	end

	// key bytes are written at cnt_q; a message item reads at its key position
	frkd_ram #(
		.WIDTH(8),
		.DEPTH(KEY_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (item_fire && wr_en),
		.waddr(cnt_q[AW-1:0]),
		.wdata(item.data_byte),
		.re   (item_fire),
		.raddr(rd_addr),
		.rdata(key_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_fire && produce) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			data_s1    <= item.data_byte;
			last_s1    <= item.frame_last;
			err_s1     <= is_err;
			use_key_s1 <= use_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_adv) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			result_q.end_of_frame <= last_s1;
			if (err_s1) begin
				result_q.plain_byte <= '0;
				result_q.status     <= STATUS_KEY_LONG;
			end else begin
				result_q.plain_byte <= use_key_s1 ? (data_s1 - key_byte) : data_s1;
				result_q.status     <= STATUS_OK;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_FULL)
		else $error("key count beyond store depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MSG && cnt_q != '0) |-> (CW'(pos_q) < cnt_q))
		else $error("key position outside key");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> valid_s1)
		else $error("pending item dropped from stage 1");

	a_delim_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && phase_q == PH_DELIM) |=> (cnt_q == '0 && pos_q == '0))
		else $error("delimiter did not clear key state");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && phase_q == PH_KEY && produce) |=> (valid_s1 && err_s1))
		else $error("key overflow gave no error item");

endmodule

// File: src/frkd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module frkd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
